### hdl/gbc_pkg.sv
// Shared types, constants and helpers for the gyro bias calibrator.
// No dependencies; imported by every module of the block.
package gbc_pkg;

    // Number of still samples averaged into one bias
    localparam int unsigned SAMPLE_COUNT = 50;

    localparam int unsigned AXIS_W  = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned LIMIT_W = 34;
    localparam int unsigned SUM_W   = 22;
    localparam int unsigned CNT_W   = $clog2(SAMPLE_COUNT + 1);
    localparam int unsigned DIFF_W  = AXIS_W + 1;
    localparam int unsigned SQ_W    = 2 * DIFF_W;
    localparam int unsigned CFG_W   = LIMIT_W;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned PHASE_W = 2;

    // Reciprocal multiply for the division of the sum by SAMPLE_COUNT
    localparam int unsigned DIV_SHIFT = SUM_W + CNT_W;
    localparam int unsigned DIV_MULT_W = DIV_SHIFT + 1;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_W'(
        ((64'd1 << DIV_SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));
    localparam int unsigned PROD_W = SUM_W + DIV_MULT_W;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECAL_PERIOD  = 2'd2;

    // Reset values of the registers
    localparam logic [LIMIT_W-1:0] RST_STILL_LIMIT   = 34'd6972;
    localparam logic [TIME_W-1:0]  RST_SAMPLE_PERIOD = 32'd10000;
    localparam logic [TIME_W-1:0]  RST_RECAL_PERIOD  = 32'd60000000;

    // Phase codes as seen on the result port
    localparam logic [PHASE_W-1:0] PHASE_CODE_COLLECT = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_COMPUTE = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE    = 2'd2;

    typedef logic signed [AXIS_W-1:0] t_axis;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef enum logic [2:0] {
        PH_COLLECT = 3'b001,
        PH_COMPUTE = 3'b010,
        PH_IDLE    = 3'b100
    } t_phase;

    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_COLLECT: code = PHASE_CODE_COLLECT;
            PH_COMPUTE: code = PHASE_CODE_COMPUTE;
            default:    code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

### hdl/gbc_still_check.sv
// Stillness test: squared accel distance from the reference against a limit.
// Depends on gbc_pkg.
module gbc_still_check
    import gbc_pkg::*;
(
    input  t_axis              i_accel [3],
    input  t_axis              i_ref   [3],
    input  logic [LIMIT_W-1:0] i_limit,
    output logic               o_still
);

    logic signed [DIFF_W-1:0] w_diff [3];
    logic [SQ_W-1:0]          w_sq   [3];
    logic [LIMIT_W-1:0]       w_dsq;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = DIFF_W'(i_ref[k]) - DIFF_W'(i_accel[k]);
            w_sq[k]   = SQ_W'(w_diff[k] * w_diff[k]);
        end
    end

    // Sum of three squares stays below 3 * 2^32
    assign w_dsq   = LIMIT_W'(w_sq[0]) + LIMIT_W'(w_sq[1]) + LIMIT_W'(w_sq[2]);
    assign o_still = (w_dsq < i_limit);

endmodule

### hdl/gbc_bias_div.sv
// Registered signed division of a gyro sum by SAMPLE_COUNT, toward zero.
// Uses a reciprocal multiply; depends on gbc_pkg.
module gbc_bias_div
    import gbc_pkg::*;
(
    input  logic  i_clk,
    input  t_sum  i_sum,
    output t_axis o_quot
);

    logic              w_neg;
    logic [SUM_W-1:0]  w_mag;
    logic [PROD_W-1:0] w_prod;
    logic [SUM_W-1:0]  w_q;
    logic [SUM_W-1:0]  w_signed_q;
    t_axis             r_quot;

    assign w_neg      = i_sum[SUM_W-1];
    assign w_mag      = w_neg ? (~i_sum + 1'b1) : i_sum;
    assign w_prod     = PROD_W'(w_mag) * PROD_W'(DIV_MULT);
    assign w_q        = SUM_W'(w_prod >> DIV_SHIFT);
    assign w_signed_q = w_neg ? (~w_q + 1'b1) : w_q;

    always_ff @(posedge i_clk) begin
        r_quot <= AXIS_W'(w_signed_q);
    end

    assign o_quot = r_quot;

endmodule

### hdl/gyro_bias_calibrator_unit.sv
// Gyro bias calibrator, top level: handshake, phase control and state.
// Depends on gbc_pkg, gbc_still_check and gbc_bias_div.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one IMU sample per item:
//   timestamp, armed flag, raw accel and raw gyro counts. Output channel
//   (o_valid / i_stall) returns exactly one result item per input item:
//   the current bias, a calibration-done flag and the phase after the item.
//   o_valid rises when the item moves from the input register to the result
//   register, which a stall can hold off: one input register, one result
//   register. Throughput is one item per cycle while the output is not
//   stalled; the phase and accumulator update for an item happens in the
//   cycle it moves from the input register to the result register.
//   When the receiver stalls, the result register holds and the input
//   register takes one more item; o_stall rises only when both are full
//   and the output is stalled, so no item is lost or repeated.
//   The division of each axis sum is done in a registered multiply stage
//   that runs every cycle; the sum is stable at least one item before the
//   compute phase reads the quotient.
//   Reset (i_rst_n low, synchronous) empties both registers, restores the
//   register defaults, clears bias, sums and reference, and enters collect.
//   Configuration writes go through i_cfg_we / i_cfg_idx / i_cfg_data;
//   an index beyond the register list is dropped.
module gyro_bias_calibrator_unit
    import gbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,

    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [TIME_W-1:0]    i_now_us,
    input  logic                 i_armed,
    input  t_axis                i_accel_x,
    input  t_axis                i_accel_y,
    input  t_axis                i_accel_z,
    input  t_axis                i_rate_x,
    input  t_axis                i_rate_y,
    input  t_axis                i_rate_z,

    output logic                 o_valid,
    input  logic                 i_stall,
    output t_axis                o_bias_x,
    output t_axis                o_bias_y,
    output t_axis                o_bias_z,
    output logic                 o_cal_done,
    output logic [PHASE_W-1:0]   o_phase
);

    // Configuration registers
    logic [LIMIT_W-1:0] r_still_limit;
    logic [TIME_W-1:0]  r_sample_period;
    logic [TIME_W-1:0]  r_recal_period;

    // Input register
    logic               r_in_valid;
    logic [TIME_W-1:0]  r_in_now;
    logic               r_in_armed;
    t_axis              r_in_accel [3];
    t_axis              r_in_rate  [3];

    // Calibration state
    t_phase             r_phase,  n_phase;
    logic [CNT_W-1:0]   r_count,  n_count;
    t_sum               r_sum [3];
    t_sum               n_sum [3];
    t_axis              r_ref [3];
    t_axis              n_ref [3];
    logic [TIME_W-1:0]  r_last,   n_last;
    t_axis              r_bias [3];
    t_axis              n_bias [3];
    logic               r_recal,  n_recal;
    logic               n_done;

    // Result register
    logic               r_out_valid;
    t_axis              r_out_bias [3];
    logic               r_out_done;
    logic [PHASE_W-1:0] r_out_phase;

    logic               w_advance;
    logic               w_accept;
    logic               w_still;
    logic               w_sample_due;
    logic               w_recal_due;
    logic               w_recal_eff;
    t_axis              w_quot [3];

    // Move an item on when the result register is empty or being taken
    assign w_advance = r_in_valid & (~r_out_valid | ~i_stall);
    assign o_stall   = r_in_valid & ~w_advance;
    assign w_accept  = i_valid & ~o_stall;

    gbc_still_check u_still (
        .i_accel (r_in_accel),
        .i_ref   (r_ref),
        .i_limit (r_still_limit),
        .o_still (w_still)
    );

    gbc_bias_div u_div_x (.i_clk(i_clk), .i_sum(r_sum[0]), .o_quot(w_quot[0]));
    gbc_bias_div u_div_y (.i_clk(i_clk), .i_sum(r_sum[1]), .o_quot(w_quot[1]));
    gbc_bias_div u_div_z (.i_clk(i_clk), .i_sum(r_sum[2]), .o_quot(w_quot[2]));

    // Both timers share one last-check stamp; wrap-safe elapsed time
    assign w_sample_due = ((r_in_now - r_last) >= r_sample_period);
    assign w_recal_due  = ((r_in_now - r_last) >= r_recal_period);

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_sum       = r_sum;
        n_ref       = r_ref;
        n_last      = r_last;
        n_bias      = r_bias;
        n_recal     = r_recal;
        n_done      = 1'b0;
        w_recal_eff = r_recal;

        case (r_phase)
            PH_COLLECT: begin
                if (r_in_armed) begin
                    // armed mid-collection: give up, keep the old bias
                    n_phase = PH_IDLE;
                end else if (w_sample_due) begin
                    n_last = r_in_now;
                    if (w_still) begin
                        if (r_count < CNT_W'(SAMPLE_COUNT)) begin
                            for (int k = 0; k < 3; k++) begin
                                n_sum[k] = r_sum[k] + SUM_W'(r_in_rate[k]);
                            end
                            n_count = r_count + 1'b1;
                        end else begin
                            n_phase = PH_COMPUTE;
                        end
                    end else begin
                        // moved: restart from the current accel
                        for (int k = 0; k < 3; k++) begin
                            n_ref[k] = r_in_accel[k];
                            n_sum[k] = '0;
                        end
                        n_count = '0;
                    end
                end
            end
            PH_COMPUTE: begin
                n_bias  = w_quot;
                n_phase = PH_IDLE;
                n_recal = 1'b0;
                n_done  = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
                if (r_in_armed) begin
                    w_recal_eff = 1'b1;
                end else if (w_recal_due) begin
                    n_last      = r_in_now;
                    w_recal_eff = 1'b1;
                end
                n_recal = w_recal_eff;
                if (~r_in_armed & w_recal_eff) begin
                    n_phase = PH_COLLECT;
                    for (int k = 0; k < 3; k++) begin
                        n_ref[k] = r_in_accel[k];
                        n_sum[k] = '0;
                    end
                    n_count = '0;
                end
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_still_limit   <= RST_STILL_LIMIT;
            r_sample_period <= RST_SAMPLE_PERIOD;
            r_recal_period  <= RST_RECAL_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STILL_LIMIT:   r_still_limit   <= i_cfg_data;
                CFG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data[TIME_W-1:0];
                CFG_RECAL_PERIOD:  r_recal_period  <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: load on accept, drop valid when the item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_now      <= i_now_us;
            r_in_armed    <= i_armed;
            r_in_accel[0] <= i_accel_x;
            r_in_accel[1] <= i_accel_y;
            r_in_accel[2] <= i_accel_z;
            r_in_rate[0]  <= i_rate_x;
            r_in_rate[1]  <= i_rate_y;
            r_in_rate[2]  <= i_rate_z;
        end
    end

    // Calibration state: advance once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COLLECT;
            r_count <= '0;
            r_last  <= '0;
            r_recal <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_sum[k]  <= '0;
                r_ref[k]  <= '0;
                r_bias[k] <= '0;
            end
        end else if (w_advance) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_last  <= n_last;
            r_recal <= n_recal;
            r_sum   <= n_sum;
            r_ref   <= n_ref;
            r_bias  <= n_bias;
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (~i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_bias  <= n_bias;
            r_out_done  <= n_done;
            r_out_phase <= phase_code(n_phase);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_bias_x   = r_out_bias[0];
    assign o_bias_y   = r_out_bias[1];
    assign o_bias_z   = r_out_bias[2];
    assign o_cal_done = r_out_done;
    assign o_phase    = r_out_phase;

endmodule

### tb/tb_top.sv
// Self-checking testbench for gyro_bias_calibrator_unit: IMU sample items in,
// bias/phase report items out, both channels under random idling and stalls.
// Depends on gbc_pkg and the calibrator RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gbc_pkg::*;

    // Index past the end of the register list; the block must drop writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES     = 6;

    // One input item and one result item, axes packed x, y, z at [0], [1], [2]
    typedef struct packed {
        logic [TIME_W-1:0]      now_us;
        logic                   armed;
        logic [2:0][AXIS_W-1:0] accel;
        logic [2:0][AXIS_W-1:0] rate;
    } t_imu_sample;

    typedef struct packed {
        logic [2:0][AXIS_W-1:0] bias;
        logic                   cal_done;
        logic [PHASE_W-1:0]     phase;
    } t_bias_report;

    // Flavor of a run of random samples
    typedef enum logic [1:0] {
        STYLE_STILL,
        STYLE_MOTION,
        STYLE_ARMED,
        STYLE_NOISE
    } t_style;

    // Tracks the calibration state, predicts one report per sample and
    // holds the reports still owed by the block.
    class bias_tracker;
        logic [LIMIT_W-1:0] still_limit;
        logic [TIME_W-1:0]  sample_period;
        logic [TIME_W-1:0]  recal_period;

        t_phase             cur_phase;
        int                 still_count;
        int                 rate_acc[3];
        int                 accel_anchor[3];
        logic [TIME_W-1:0]  last_tick;
        int                 bias_now[3];
        bit                 recal_due;

        t_bias_report       pending_bias[$];
        int unsigned        fail_count;

        function new();
            still_limit   = RST_STILL_LIMIT;
            sample_period = RST_SAMPLE_PERIOD;
            recal_period  = RST_RECAL_PERIOD;
            cur_phase     = PH_COLLECT;
            still_count   = 0;
            last_tick     = '0;
            recal_due     = 1'b0;
            fail_count    = 0;
            for (int i = 0; i < 3; i++) begin
                rate_acc[i]     = 0;
                accel_anchor[i] = 0;
                bias_now[i]     = 0;
            end
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
            case (idx)
                CFG_STILL_LIMIT:   still_limit = data;
                CFG_SAMPLE_PERIOD: sample_period = data[TIME_W-1:0];
                CFG_RECAL_PERIOD:  recal_period = data[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        // Wrapping timer shared by the sample and recalibration checks
        function bit tick_due(input logic [TIME_W-1:0] now,
                              input logic [TIME_W-1:0] period);
            logic [TIME_W-1:0] gap;
            gap = now - last_tick;
            if (gap >= period) begin
                last_tick = now;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void restart_window(input int acc[3]);
            for (int i = 0; i < 3; i++) begin
                accel_anchor[i] = acc[i];
                rate_acc[i]     = 0;
            end
            still_count = 0;
        endfunction

        function void note_sample(input t_imu_sample s);
            int              acc[3];
            int              rate[3];
            longint          d;
            longint unsigned drift_sq;
            bit              done;
            t_bias_report    r;
            done = 1'b0;
            for (int i = 0; i < 3; i++) begin
                acc[i]  = $signed(s.accel[i]);
                rate[i] = $signed(s.rate[i]);
            end
            case (cur_phase)
                PH_COLLECT: begin
                    if (s.armed) begin
                        cur_phase = PH_IDLE;
                    end else if (tick_due(s.now_us, sample_period)) begin
                        drift_sq = 0;
                        for (int i = 0; i < 3; i++) begin
                            d = longint'(accel_anchor[i]) - longint'(acc[i]);
                            drift_sq += d * d;
                        end
                        if (drift_sq < still_limit) begin
                            if (still_count < SAMPLE_COUNT) begin
                                for (int i = 0; i < 3; i++)
                                    rate_acc[i] += rate[i];
                                still_count++;
                            end else begin
                                cur_phase = PH_COMPUTE;
                            end
                        end else begin
                            restart_window(acc);
                        end
                    end
                end
                PH_COMPUTE: begin
                    for (int i = 0; i < 3; i++)
                        bias_now[i] = rate_acc[i] / int'(SAMPLE_COUNT);
                    cur_phase = PH_IDLE;
                    recal_due = 1'b0;
                    done      = 1'b1;
                end
                default: begin
                    cur_phase = PH_IDLE;
                    if (s.armed)
                        recal_due = 1'b1;
                    if (!s.armed && tick_due(s.now_us, recal_period))
                        recal_due = 1'b1;
                    if (!s.armed && recal_due) begin
                        cur_phase = PH_COLLECT;
                        restart_window(acc);
                    end
                end
            endcase
            for (int i = 0; i < 3; i++)
                r.bias[i] = AXIS_W'(bias_now[i]);
            r.cal_done = done;
            case (cur_phase)
                PH_COLLECT: r.phase = PHASE_CODE_COLLECT;
                PH_COMPUTE: r.phase = PHASE_CODE_COMPUTE;
                default:    r.phase = PHASE_CODE_IDLE;
            endcase
            pending_bias.push_back(r);
        endfunction

        function void check_report(input t_bias_report got);
            t_bias_report want;
            if (pending_bias.size() == 0) begin
                $display("%0t: report with nothing outstanding, bias %0d %0d %0d phase %0d",
                         $time, $signed(got.bias[0]), $signed(got.bias[1]),
                         $signed(got.bias[2]), got.phase);
                fail_count++;
                return;
            end
            want = pending_bias.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (got.bias[i] !== want.bias[i]) begin
                    $display("%0t: bias axis %0d expected %0d actual %0d", $time, i,
                             $signed(want.bias[i]), $signed(got.bias[i]));
                    fail_count++;
                end
            end
            if (got.cal_done !== want.cal_done) begin
                $display("%0t: cal_done expected %0d actual %0d", $time,
                         want.cal_done, got.cal_done);
                fail_count++;
            end
            if (got.phase !== want.phase) begin
                $display("%0t: phase expected %0d actual %0d", $time,
                         want.phase, got.phase);
                fail_count++;
            end
        endfunction

        function int pending_count();
            return pending_bias.size();
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // Block ports; every input starts at a known value
    // ---------------------------------------------------------------------
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid    = 1'b0;
    logic                 o_stall;
    logic [TIME_W-1:0]    i_now_us   = '0;
    logic                 i_armed    = 1'b0;
    t_axis                i_accel_x  = '0;
    t_axis                i_accel_y  = '0;
    t_axis                i_accel_z  = '0;
    t_axis                i_rate_x   = '0;
    t_axis                i_rate_y   = '0;
    t_axis                i_rate_z   = '0;
    logic                 o_valid;
    logic                 i_stall    = 1'b0;
    t_axis                o_bias_x;
    t_axis                o_bias_y;
    t_axis                o_bias_z;
    logic                 o_cal_done;
    logic [PHASE_W-1:0]   o_phase;

    gyro_bias_calibrator_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_now_us   (i_now_us),
        .i_armed    (i_armed),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .i_rate_x   (i_rate_x),
        .i_rate_y   (i_rate_y),
        .i_rate_z   (i_rate_z),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_bias_x   (o_bias_x),
        .o_bias_y   (o_bias_y),
        .o_bias_z   (o_bias_z),
        .o_cal_done (o_cal_done),
        .o_phase    (o_phase)
    );

    // 8 ns clock, first rising edge at 4 ns
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    bias_tracker tracker = new();

    // Stimulus state: running timestamp, mirrored periods, the still point
    // and gyro level of the current session, and the sender's burst budget
    logic [TIME_W-1:0] clock_us;
    logic [TIME_W-1:0] cur_sample = RST_SAMPLE_PERIOD;
    logic [TIME_W-1:0] cur_recal  = RST_RECAL_PERIOD;
    int                base_acc[3];
    int                base_rate[3];
    int                jitter;
    int unsigned       burst_left = 0;
    bit                long_hold_req = 1'b0;
    int unsigned       cycle_count = 0;

    // ---------------------------------------------------------------------
    // Monitors: sample handshakes on the edge, before any update lands
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_imu_sample  s;
        t_bias_report r;
        if (i_rst_n && i_valid && !o_stall) begin
            s.now_us   = i_now_us;
            s.armed    = i_armed;
            s.accel[0] = i_accel_x;
            s.accel[1] = i_accel_y;
            s.accel[2] = i_accel_z;
            s.rate[0]  = i_rate_x;
            s.rate[1]  = i_rate_y;
            s.rate[2]  = i_rate_z;
            tracker.note_sample(s);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            r.bias[0]  = o_bias_x;
            r.bias[1]  = o_bias_y;
            r.bias[2]  = o_bias_z;
            r.cal_done = o_cal_done;
            r.phase    = o_phase;
            tracker.check_report(r);
        end
    end

    // Watchdog: give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: stall in stretches of varying density; on request, hold
    // off for a long run so the block backs up and stalls its input
    // ---------------------------------------------------------------------
    initial begin : stall_pattern
        int unsigned run_len;
        int unsigned pct;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end
            run_len = $urandom_range(4, 60);
            case ($urandom_range(0, 3))
                0:       pct = 0;
                1:       pct = 25;
                2:       pct = 60;
                default: pct = 90;
            endcase
            repeat (run_len) begin
                i_stall <= ($urandom_range(0, 99) < pct);
                @(posedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------------

    // Offer one item; open a new burst after a random gap when the current
    // one is used up, then hold the item until the block takes it.
    task automatic offer(input t_imu_sample s);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_now_us  <= s.now_us;
        i_armed   <= s.armed;
        i_accel_x <= s.accel[0];
        i_accel_y <= s.accel[1];
        i_accel_z <= s.accel[2];
        i_rate_x  <= s.rate[0];
        i_rate_y  <= s.rate[1];
        i_rate_z  <= s.rate[2];
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic offer_fields(input logic [TIME_W-1:0] now, input logic armed,
                                input int ax, input int ay, input int az,
                                input int rx, input int ry, input int rz);
        t_imu_sample s;
        s.now_us   = now;
        s.armed    = armed;
        s.accel[0] = AXIS_W'(ax);
        s.accel[1] = AXIS_W'(ay);
        s.accel[2] = AXIS_W'(az);
        s.rate[0]  = AXIS_W'(rx);
        s.rate[1]  = AXIS_W'(ry);
        s.rate[2]  = AXIS_W'(rz);
        clock_us   = now;
        offer(s);
    endtask

    // Drop valid and wait until every report has come back, then let the block
    // drain; advance the clock before the first check so the last accepted item is counted
    task automatic settle();
        i_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (tracker.pending_count() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers back to back (random bits above the 32-bit
    // ones), optionally followed by a write to the unused index
    task automatic program_regs(input logic [CFG_W-1:0] limit_val,
                                input logic [TIME_W-1:0] sample_val,
                                input logic [TIME_W-1:0] recal_val,
                                input bit poke_unused);
        logic [CFG_IDX_W-1:0] idx_list[4];
        logic [CFG_W-1:0]     data_list[4];
        int                   n;
        idx_list[0]  = CFG_STILL_LIMIT;
        data_list[0] = limit_val;
        idx_list[1]  = CFG_SAMPLE_PERIOD;
        data_list[1] = {2'($urandom), sample_val};
        idx_list[2]  = CFG_RECAL_PERIOD;
        data_list[2] = {2'($urandom), recal_val};
        idx_list[3]  = CFG_UNUSED;
        data_list[3] = {2'($urandom), 32'($urandom)};
        n = poke_unused ? 4 : 3;
        for (int k = 0; k < n; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[k];
            i_cfg_data <= data_list[k];
            tracker.write_reg(idx_list[k], data_list[k]);
            @(posedge i_clk);
        end
        i_cfg_we   <= 1'b0;
        cur_sample = sample_val;
        cur_recal  = recal_val;
    endtask

    // Build one random sample of the given flavor. Still samples sit near
    // the session's point with time stepping past the sample period most of
    // the time; now and then time jumps a whole recalibration period.
    task automatic make_sample(input t_style st, output t_imu_sample s);
        logic [TIME_W-1:0] step;
        if (st == STYLE_NOISE) begin
            s.now_us = $urandom;
            s.armed  = $urandom_range(0, 1);
            for (int k = 0; k < 3; k++) begin
                s.accel[k] = AXIS_W'($urandom);
                s.rate[k]  = AXIS_W'($urandom);
            end
            clock_us = s.now_us;
            return;
        end
        if ($urandom_range(0, 39) == 0)
            step = cur_recal + $urandom_range(0, 3);
        else if ($urandom_range(0, 9) == 0)
            step = $urandom_range(0, cur_sample);
        else
            step = cur_sample + $urandom_range(0, 3 + cur_sample / 8);
        clock_us += step;
        s.now_us = clock_us;
        s.armed  = (st == STYLE_ARMED);
        for (int k = 0; k < 3; k++) begin
            if (st == STYLE_MOTION)
                s.accel[k] = AXIS_W'(base_acc[k] + int'($urandom_range(0, 400)) - 200);
            else
                s.accel[k] = AXIS_W'(base_acc[k] + int'($urandom_range(0, 2 * jitter))
                                     - jitter);
            if ($urandom_range(0, 4) == 0)
                s.rate[k] = AXIS_W'($urandom);
            else
                s.rate[k] = AXIS_W'(base_rate[k] + int'($urandom_range(0, 64)) - 32);
        end
    endtask

    // Mostly long still sessions that can reach a full calibration, broken
    // up by motion, arming and pure noise
    task automatic run_random(input int unsigned count);
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        t_style      st;
        t_imu_sample s;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                st  = STYLE_STILL;
                len = $urandom_range(20, 120);
                if ($urandom_range(0, 1) == 0) begin
                    for (int k = 0; k < 3; k++) begin
                        base_acc[k]  = int'($urandom_range(0, 65535 - 96)) - 32720;
                        base_rate[k] = int'($urandom_range(0, 65535)) - 32768;
                    end
                end
                jitter = ($urandom_range(0, 3) == 0) ? $urandom_range(25, 48)
                                                     : $urandom_range(0, 24);
            end else if (pick < 70) begin
                st  = STYLE_MOTION;
                len = $urandom_range(1, 6);
            end else if (pick < 82) begin
                st  = STYLE_ARMED;
                len = $urandom_range(1, 6);
            end else begin
                st  = STYLE_NOISE;
                len = $urandom_range(1, 8);
            end
            for (int unsigned j = 0; j < len && sent < count; j++) begin
                make_sample(st, s);
                offer(s);
                sent++;
            end
        end
    endtask

    // Hand-picked samples at reset settings: timer below and across the
    // wrap, the stillness limit from both sides, field extremes, arming in
    // collect and in idle, and a pending recalibration request
    task automatic directed();
        offer_fields(32'd0, 1'b0, 0, 0, 0, 0, 0, 0);
        // Reference starts at zero, so the first check sees motion
        offer_fields(32'd10000, 1'b0, 100, -50, 20, 5, 5, 5);
        // Drift of 6971 counts squared: still
        offer_fields(32'd20000, 1'b0, 183, -41, 21, 32767, 32767, 32767);
        // Drift of 6974: moved, restart from here
        offer_fields(32'd30000, 1'b0, 183, -41, 22, -32768, -32768, -32768);
        // Inside the period: no check
        offer_fields(32'd35000, 1'b0, 183, -41, 22, 1, 2, 3);
        // Timer across the 32-bit wrap
        offer_fields(32'hFFFF_F000, 1'b0, 183, -41, 22, -32768, 32767, 0);
        offer_fields(32'h0000_2000, 1'b0, 183, -41, 22, 7, -7, 100);
        // Arm in collect: go idle, keep bias; arm in idle: ask for recal
        offer_fields(32'h0000_3000, 1'b1, 183, -41, 22, 0, 0, 0);
        offer_fields(32'h0000_4000, 1'b1, 0, 0, 0, 0, 0, 0);
        offer_fields(32'h0000_5000, 1'b0, -32768, 32767, -32768, 0, 0, 0);
        // Largest possible drift
        offer_fields(32'h0000_5000 + 32'd10000, 1'b0, 32767, -32768, 32767, 9, 9, 9);
        offer_fields(32'h0000_5000 + 32'd20000, 1'b0, 32767, -32768, 32767, -1, -1, -1);
        offer_fields(32'hFFFF_FFFF, 1'b0, -1, -1, -1, 32767, -32768, 32767);
        offer_fields(32'hFFFF_FFFF, 1'b1, 0, 0, 0, 0, 0, 0);
        // Idle, disarmed, recalibration still pending from the arm in idle: back to collect
        offer_fields(32'd0, 1'b0, 0, 0, 0, 0, 0, 0);
        offer_fields(32'd60000000, 1'b0, 12, -12, 4000, 3, 3, 3);
    endtask

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        for (int k = 0; k < 3; k++) begin
            base_acc[k]  = 0;
            base_rate[k] = 0;
        end
        jitter   = 0;
        clock_us = '0;

        // Hold reset low, then release
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed();

        // Reset settings; the receiver backs off for a long stretch early on
        long_hold_req = 1'b1;
        run_random(300);

        // Widest limit and zero periods: every timer check is due and every sample is still
        settle();
        program_regs({CFG_W{1'b1}}, '0, '0, 1'b1);
        run_random(250);

        // Zero limit and longest periods: nothing is ever still
        settle();
        program_regs('0, {TIME_W{1'b1}}, {TIME_W{1'b1}}, 1'b0);
        run_random(80);

        // Moderate random settings with short periods
        settle();
        program_regs(CFG_W'($urandom_range(2000, 20000)), $urandom_range(1, 200),
                     $urandom_range(300, 5000), 1'b1);
        run_random(220);
        // Pause the sender until the block has answered everything
        settle();
        run_random(230);

        settle();
        if (tracker.fail_count == 0 && tracker.pending_count() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
hdl/gbc_pkg.sv
hdl/gbc_still_check.sv
hdl/gbc_bias_div.sv
hdl/gyro_bias_calibrator_unit.sv
tb/tb_top.sv
